FILE: src/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared constants and types for the palindromic tree builder.
// ----------------------------------------------------------------------------
package ptb_pkg;
  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 26;
  localparam int LETTER_W     = 5;
  localparam int FIELD_W      = 11;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                full;
  } ptb_cmd_t;
endpackage

FILE: src/palindromic_tree_builder.sv
// The sequential back end finishes each letter before it takes the next one.
// Synchronous reset, then a clearing pass sweeps the child table; the front
// queues up to two letters meanwhile.
// ----------------------------------------------------------------------------
// palindromic_tree_builder
// Online eertree: front queue of letters, back sequencer over the tables.
// ----------------------------------------------------------------------------
module palindromic_tree_builder import ptb_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LETTER_W-1:0] in_letter,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FIELD_W-1:0]  out_suffix_node,
  output logic [FIELD_W-1:0]  out_suffix_len,
  output logic                out_new_node,
  output logic [FIELD_W-1:0]  out_first_pos,
  output logic [FIELD_W-1:0]  out_distinct_count,
  output logic                out_full_res
);
  logic q_valid, q_pop;
  ptb_cmd_t q_cmd;

  ptb_front #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_letter, .q_valid, .q_pop, .q_cmd);

  ptb_back #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd, .out_valid, .out_ready,
    .out_suffix_node, .out_suffix_len, .out_new_node, .out_first_pos,
    .out_distinct_count, .out_full_res);
endmodule

FILE: src/ptb_ram.sv
// ----------------------------------------------------------------------------
// ptb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: src/ptb_front.sv
// ----------------------------------------------------------------------------
// ptb_front
// Takes letters, reduces them into the alphabet, marks refusals once the text
// is full and pushes commands into a two-entry queue.
// ----------------------------------------------------------------------------
module ptb_front import ptb_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF,
  parameter int PW       = $clog2(MAX_LEN + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LETTER_W-1:0] in_letter,
  output logic                q_valid,
  input  logic                q_pop,
  output ptb_cmd_t            q_cmd
);
  ptb_cmd_t     q_r [2];
  logic [1:0]   cnt_r, cnt_nxt;
  logic         rd_r, rd_nxt;
  logic         wr_r, wr_nxt;
  logic [PW-1:0] len_r, len_nxt;
  logic         push;
  ptb_cmd_t     cmd;

  // letter code folded into the alphabet by a small lookup
  function automatic logic [LETTER_W-1:0] fold(input logic [LETTER_W-1:0] v);
    fold = '0;
    for (int k = 0; k < 2**LETTER_W; k++) begin
      if (v == LETTER_W'(k)) fold = LETTER_W'(k % ALPHABET);
    end
  endfunction

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rd_r];

  always_comb begin
    cmd.letter = fold(in_letter);
    cmd.full   = (len_r == PW'(MAX_LEN));
    len_nxt = len_r;
    if (push && !cmd.full) len_nxt = len_r + PW'(1);
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0; len_r <= '0;
    end else begin
      cnt_r <= cnt_nxt; rd_r <= rd_nxt; wr_r <= wr_nxt; len_r <= len_nxt;
    end
    if (push) q_r[wr_r] <= cmd;
  end
endmodule

FILE: src/ptb_back.sv
// ----------------------------------------------------------------------------
// ptb_back
// Sequencer that stores the letter, walks suffix links, creates nodes and
// forms the transaction on the result channel.
// ----------------------------------------------------------------------------
module ptb_back import ptb_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF,
  parameter int PW       = $clog2(MAX_LEN + 1),
  parameter int NW       = $clog2(MAX_LEN + 2)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  ptb_cmd_t           q_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_suffix_node,
  output logic [FIELD_W-1:0] out_suffix_len,
  output logic               out_new_node,
  output logic [FIELD_W-1:0] out_first_pos,
  output logic [FIELD_W-1:0] out_distinct_count,
  output logic               out_full_res
);
  localparam int NODES = MAX_LEN + 2;
  localparam int CT    = NODES * ALPHABET;
  localparam int CW    = $clog2(CT);
  localparam int LW    = PW + 1;

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_CHK = 4'd3,
                         S_CH  = 4'd4, S_CHW = 4'd5, S_LK = 4'd6, S_LKW = 4'd7,
                         S_CH2 = 4'd8, S_CH2W = 4'd9, S_WR = 4'd10, S_OUT = 4'd11,
                         S_FO  = 4'd12, S_TX = 4'd13;

  logic [3:0] st_r;
  logic [CW-1:0] clr_r;
  logic [NW-1:0] last_r, cnt_r, v_r, cur_r, x_r, node_r;
  logic [PW-1:0] pos_r;
  logic [LETTER_W-1:0] c_r;
  logic second_r, new_r, full_r;

  // memories
  logic t_we; logic [PW-1:0] t_wa, t_ra; logic [LETTER_W-1:0] t_wd, t_rd;
  logic c_we; logic [CW-1:0] c_wa, c_ra; logic [NW-1:0] c_wd, c_rd;
  logic s_we; logic [NW-1:0] s_wa, s_ra, s_wd, s_rd;
  logic l_we; logic [NW-1:0] l_wa, l_ra; logic [LW-1:0] l_wd, l_rd;
  logic p_we; logic [NW-1:0] p_wa, p_ra; logic [PW-1:0] p_wd, p_rd;
  logic [LW-1:0] len_v_r, len_cur_r;
  logic [NW-1:0] lnk_v_r;

  ptb_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_LEN + 1)) u_text (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  ptb_ram #(.WIDTH(NW), .DEPTH(CT)) u_child (
    .clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  ptb_ram #(.WIDTH(NW), .DEPTH(NODES)) u_link (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  ptb_ram #(.WIDTH(LW), .DEPTH(NODES)) u_len (
    .clk, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
  ptb_ram #(.WIDTH(PW), .DEPTH(NODES)) u_start (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  // node with index at or below 1 is a root; length field is 2's complement
  logic          odd_v;
  logic signed [LW+1:0] idx;

  assign odd_v = (v_r == NW'(1));
  // length read is valid from S_TX on; text read at idx is valid in S_CHK
  assign idx = $signed({2'b00, pos_r}) - 2'sd1 - $signed({l_rd[LW-1], l_rd});

  function automatic logic [CW-1:0] slot(input logic [NW-1:0] n, input logic [LETTER_W-1:0] c);
    slot = CW'(n * ALPHABET) + CW'(c);
  endfunction

  // text is read at idx; sentinel position 0 never matches
  logic t_ok;
  assign t_ok = (idx >= 0) && (idx != 0);

  always_comb begin
    t_we = 1'b0; t_wa = pos_r; t_wd = c_r; t_ra = idx[PW-1:0];
    c_we = 1'b0; c_wa = clr_r; c_wd = '0; c_ra = slot(cur_r, c_r);
    s_we = 1'b0; s_wa = x_r; s_wd = '0; s_ra = v_r;
    l_we = 1'b0; l_wa = x_r; l_wd = '0; l_ra = v_r;
    p_we = 1'b0; p_wa = x_r; p_wd = '0; p_ra = node_r;
    if (st_r == S_CLR) begin
      c_we = 1'b1;
      s_we = (clr_r < CW'(2)); s_wa = clr_r[NW-1:0]; s_wd = NW'(1);
      l_we = (clr_r < CW'(2)); l_wa = clr_r[NW-1:0];
      l_wd = clr_r[0] ? '1 : '0;
      p_we = (clr_r < CW'(2)); p_wa = clr_r[NW-1:0];
    end
    if (st_r == S_IDLE && q_valid && !q_cmd.full) begin
      t_we = 1'b1; t_wa = pos_r + PW'(1); t_wd = q_cmd.letter;
    end
    if (st_r == S_CH2) c_ra = slot(v_r, c_r);
    if (st_r == S_WR) begin
      c_we = 1'b1; c_wa = slot(cur_r, c_r); c_wd = x_r;
      l_we = 1'b1; l_wd = len_cur_r + LW'(2);
      s_we = 1'b1; s_wd = lnk_v_r;
      p_we = 1'b1;
      p_wd = PW'(pos_r - l_wd[PW-1:0] + PW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; last_r <= '0; cnt_r <= NW'(1); pos_r <= '0;
      v_r <= '0; second_r <= 1'b0;
    end else begin
      case (st_r)
        S_CLR: begin
          if (clr_r == CW'(CT - 1)) st_r <= S_IDLE;
          clr_r <= clr_r + CW'(1);
        end
        S_IDLE: if (q_valid) begin
          c_r <= q_cmd.letter; full_r <= q_cmd.full; new_r <= 1'b0;
          if (q_cmd.full) begin
            node_r <= last_r; st_r <= S_FO;
          end else begin
            pos_r <= pos_r + PW'(1); v_r <= last_r; second_r <= 1'b0; st_r <= S_RD;
          end
        end
        S_RD: st_r <= S_TX;
        S_TX: st_r <= S_CHK;
        S_CHK: begin
          if (t_ok && t_rd == c_r || odd_v || v_r >= NW'(NODES)) begin
            if (!second_r) begin
              cur_r <= (v_r >= NW'(NODES)) ? NW'(1) : v_r; len_cur_r <= l_rd;
              lnk_v_r <= s_rd; st_r <= S_CH;
            end else st_r <= S_CH2;
          end else begin
            v_r <= s_rd; st_r <= S_RD;
          end
        end
        S_CH: st_r <= S_CHW;
        S_CHW: begin
          if (c_rd == '0 && cnt_r + NW'(1) < NW'(NODES)) begin
            x_r <= cnt_r + NW'(1); cnt_r <= cnt_r + NW'(1); new_r <= 1'b1;
            if (cur_r == NW'(1)) begin
              lnk_v_r <= '0; st_r <= S_WR;
            end else begin
              v_r <= lnk_v_r; second_r <= 1'b1; st_r <= S_RD;
            end
          end else begin
            node_r <= c_rd; st_r <= S_FO;
          end
        end
        S_CH2: st_r <= S_CH2W;
        S_CH2W: begin lnk_v_r <= c_rd; st_r <= S_WR; end
        S_WR: begin node_r <= x_r; st_r <= S_FO; end
        S_FO: begin v_r <= node_r; st_r <= S_LK; end
        S_LK: st_r <= S_LKW;
        S_LKW: begin
          len_v_r <= l_rd; last_r <= node_r; st_r <= S_OUT;
        end
        S_OUT: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // S_LK addresses p_ra via node_r and l_ra via v_r; rdata valid in S_LKW
  logic [PW-1:0] fp_r;
  always_ff @(posedge clk) if (st_r == S_LKW) fp_r <= p_rd;

  assign q_pop   = (st_r == S_IDLE) && q_valid;
  assign out_valid = (st_r == S_OUT);
  assign out_suffix_node = FIELD_W'(last_r);
  assign out_suffix_len  = len_v_r[LW-1] ? '0 : FIELD_W'(len_v_r);
  assign out_new_node    = new_r;
  assign out_first_pos   = FIELD_W'(fp_r);
  assign out_distinct_count = FIELD_W'(cnt_r - NW'(1));
  assign out_full_res    = full_r;
endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the palindromic tree builder: directed letters,
// shaped random text, each result transaction compared against a local
// eertree predictor or, for a typed row, its typed expectation.
// ----------------------------------------------------------------------------
module tb;
  import ptb_pkg::*;

  localparam int MAXL   = MAX_LEN_DEF;
  localparam int ALPH   = ALPHABET_DEF;
  localparam int NNODES = MAXL + 2;
  localparam int LIMIT  = 1500000;
  localparam int N_RAND = 430;

  typedef struct packed {
    logic [FIELD_W-1:0] node;
    logic [FIELD_W-1:0] len;
    logic               is_new;
    logic [FIELD_W-1:0] fpos;
    logic [FIELD_W-1:0] count;
    logic               full;
  } pal_res_t;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                typed;
    pal_res_t            res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [LETTER_W-1:0] in_letter = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [FIELD_W-1:0]  out_suffix_node;
  logic [FIELD_W-1:0]  out_suffix_len;
  logic                out_new_node;
  logic [FIELD_W-1:0]  out_first_pos;
  logic [FIELD_W-1:0]  out_distinct_count;
  logic                out_full_res;

  palindromic_tree_builder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_letter(in_letter),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_suffix_node(out_suffix_node), .out_suffix_len(out_suffix_len),
    .out_new_node(out_new_node), .out_first_pos(out_first_pos),
    .out_distinct_count(out_distinct_count), .out_full_res(out_full_res)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  int text_sym [0:MAXL];
  int child [0:NNODES*ALPH-1];
  int slink [0:NNODES-1];
  int plen [0:NNODES-1];
  int spos [0:NNODES-1];
  int last_nd, node_cnt, tpos;

  pal_res_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  int sent_hist[$];

  function automatic void tree_reset();
    foreach (child[k]) child[k] = 0;
    foreach (slink[k]) begin
      slink[k] = 1; plen[k] = 0; spos[k] = 0;
    end
    foreach (text_sym[k]) text_sym[k] = 0;
    text_sym[0] = -1;
    plen[1] = -1;
    last_nd = 0; node_cnt = 1; tpos = 0;
  endfunction

  function automatic int walk_links(int v, int i);
    int idx;
    for (int s = 0; s < NNODES + 1; s++) begin
      if (v >= NNODES) return 1;
      idx = i - 1 - plen[v];
      if (idx >= 0 && idx <= i && text_sym[idx] == text_sym[i]) return v;
      if (v == 1) return 1;
      v = slink[v];
    end
    return 1;
  endfunction

  function automatic pal_res_t report(int nd, bit nw, bit fl);
    pal_res_t r;
    r.node   = nd[FIELD_W-1:0];
    r.len    = plen[nd] > 0 ? plen[nd][FIELD_W-1:0] : '0;
    r.is_new = nw;
    r.fpos   = spos[nd][FIELD_W-1:0];
    r.count  = FIELD_W'(node_cnt - 1);
    r.full   = fl;
    return r;
  endfunction

  function automatic pal_res_t extend_tree(logic [LETTER_W-1:0] letter);
    int c, i, cur, slot, x, p;
    bit nw;
    c = int'(letter) % ALPH;
    nw = 0;
    if (tpos >= MAXL) return report(last_nd, 1'b0, 1'b1);
    i = tpos + 1;
    text_sym[i] = c;
    tpos = i;
    cur = walk_links(last_nd, i);
    slot = cur * ALPH + c;
    if (child[slot] == 0 && node_cnt + 1 < NNODES) begin
      x = node_cnt + 1;
      node_cnt = x;
      plen[x] = plen[cur] + 2;
      if (cur == 1) slink[x] = 0;
      else begin
        p = walk_links(slink[cur], i);
        slink[x] = child[p * ALPH + c];
      end
      child[slot] = x;
      spos[x] = i - plen[x] + 1;
      nw = 1;
    end
    last_nd = child[slot];
    return report(last_nd, nw, 1'b0);
  endfunction

  task automatic send_letter(logic [LETTER_W-1:0] letter, bit typed, pal_res_t tres);
    pal_res_t r;
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_letter <= letter;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = extend_tree(letter);
    expected_q.push_back(typed ? tres : r);
    sent_hist.push_back(int'(letter));
  endtask

  always @(posedge clk) begin
    pal_res_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_suffix_node !== e.node) begin
          $error("suffix_node exp %0d got %0d", e.node, out_suffix_node); errors++;
        end
        if (out_suffix_len !== e.len) begin
          $error("suffix_len exp %0d got %0d", e.len, out_suffix_len); errors++;
        end
        if (out_new_node !== e.is_new) begin
          $error("new_node exp %0d got %0d", e.is_new, out_new_node); errors++;
        end
        if (out_first_pos !== e.fpos) begin
          $error("first_pos exp %0d got %0d", e.fpos, out_first_pos); errors++;
        end
        if (out_distinct_count !== e.count) begin
          $error("distinct_count exp %0d got %0d", e.count, out_distinct_count);
          errors++;
        end
        if (out_full_res !== e.full) begin
          $error("full_res exp %0d got %0d", e.full, out_full_res); errors++;
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
      end else begin
        n = $urandom_range(1, 4);
        out_ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  dir_row_t dir_tab[20];

  initial begin
    pal_res_t none;
    int mode, k, m;
    logic [LETTER_W-1:0] l;
    none = '0;
    tree_reset();
    // first letter after reset: new single-letter node
    dir_tab[0] = '{5'd0, 1'b1, '{11'd2, 11'd1, 1'b1, 11'd1, 11'd1, 1'b0}};
    dir_tab[1] = '{5'd0, 1'b0, none};
    dir_tab[2] = '{5'd0, 1'b0, none};
    dir_tab[3] = '{5'd1, 1'b0, none};
    dir_tab[4] = '{5'd0, 1'b0, none};
    dir_tab[5] = '{5'd0, 1'b0, none};
    dir_tab[6] = '{5'd25, 1'b0, none};
    dir_tab[7] = '{5'd31, 1'b0, none};
    dir_tab[8] = '{5'd26, 1'b0, none};
    dir_tab[9] = '{5'd0, 1'b0, none};
    dir_tab[10] = '{5'd5, 1'b0, none};
    dir_tab[11] = '{5'd25, 1'b0, none};
    dir_tab[12] = '{5'd30, 1'b0, none};
    dir_tab[13] = '{5'd4, 1'b0, none};
    dir_tab[14] = '{5'd1, 1'b0, none};
    dir_tab[15] = '{5'd27, 1'b0, none};
    dir_tab[16] = '{5'd16, 1'b0, none};
    dir_tab[17] = '{5'd8, 1'b0, none};
    dir_tab[18] = '{5'd16, 1'b0, none};
    dir_tab[19] = '{5'd27, 1'b0, none};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[r]) send_letter(dir_tab[r].letter, dir_tab[r].typed, dir_tab[r].res);

    k = 0;
    while (k < N_RAND) begin
      if (k >= N_RAND - 60) quiet = 1;
      mode = $urandom_range(0, 9);
      m = $urandom_range(4, 24);
      for (int j = 0; j < m; j++) begin
        case (mode)
          0, 1, 2: l = LETTER_W'($urandom_range(0, 1));
          3, 4:    l = LETTER_W'($urandom_range(0, 3));
          5, 6: begin
            if (sent_hist.size() > 2 * j + 1)
              l = LETTER_W'(sent_hist[sent_hist.size() - 2 * j - 2]);
            else
              l = LETTER_W'($urandom_range(0, 2));
          end
          7:       l = LETTER_W'($urandom_range(0, 25));
          default: l = LETTER_W'($urandom_range(0, 31));
        endcase
        send_letter(l, 1'b0, none);
        k++;
      end
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

FILE: files.f
src/ptb_pkg.sv
src/ptb_ram.sv
src/ptb_front.sv
src/ptb_back.sv
src/palindromic_tree_builder.sv
tb/tb.sv
